### rtl/nearest_upsample_3d_gradient_sum_unit_macros.svh
// Assertion macros shared by the accumulator gradient-sum RTL.
// NUS3G_CHECK expects signals named clk and rst, NUS3G_CHECK_RST only clk, in the scope where they are used.
`ifndef NEAREST_UPSAMPLE_3D_GRADIENT_SUM_UNIT_MACROS_SVH
`define NEAREST_UPSAMPLE_3D_GRADIENT_SUM_UNIT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define NUS3G_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define NUS3G_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/nus3g_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nus3g_pkg
// Shared types and fixed widths for the 3-D nearest upsampling gradient sum.
// ----------------------------------------------------------------------------
package nus3g_pkg;

  localparam int SUM_BITS        = 41;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int SCALE_BITS      = 4;
  localparam int WIDTH_REG_BITS  = 7;
  localparam int HEIGHT_REG_BITS = 7;
  localparam int DEPTH_REG_BITS  = 10;
  localparam int PLANE_BITS      = 16;
  localparam int MAX_IN_DEPTH    = 512;

  typedef logic signed [SUM_BITS-1:0] sum_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SCALE       = 3'd0,
    CFG_IN_WIDTH    = 3'd1,
    CFG_IN_HEIGHT   = 3'd2,
    CFG_IN_DEPTH    = 3'd3,
    CFG_PLANE_TOTAL = 3'd4
  } cfg_index_t;

  // Position flags of one sample inside its scale x scale x scale block.
  typedef struct packed {
    logic first;
    logic last;
    logic pend;
  } pos_t;

endpackage

### rtl/nus3g_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nus3g stream interfaces
// Valid/ready channels for gradient samples in and block sums out.
// ----------------------------------------------------------------------------
interface nus3g_in_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] grad_value;

  modport source (output valid, output grad_value, input ready);
  modport sink (input valid, input grad_value, output ready);
endinterface

interface nus3g_out_if;
  logic                   valid;
  logic                   ready;
  nus3g_pkg::sum_t        grad_sum;
  logic                   plane_end;

  modport source (output valid, output grad_sum, output plane_end, input ready);
  modport sink (input valid, input grad_sum, input plane_end, output ready);
endinterface

### rtl/nus3g_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nus3g_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nus3g_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/nus3g_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nus3g_seq
// Configuration registers and raster position counters of the sample stream.
// ----------------------------------------------------------------------------
module nus3g_seq #(
  parameter int MAX_IN_WIDTH  = 64,
  parameter int MAX_IN_HEIGHT = 64,
  parameter int MAX_SCALE     = 8,
  localparam int AW = (MAX_IN_WIDTH * MAX_IN_HEIGHT > 1) ?
                      $clog2(MAX_IN_WIDTH * MAX_IN_HEIGHT) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [nus3g_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [nus3g_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                  advance,
  output logic [AW-1:0]                         addr,
  output nus3g_pkg::pos_t                       pos
);

  localparam int SW  = $clog2(MAX_SCALE);
  localparam int SEW = $clog2(MAX_SCALE + 1);
  localparam int CW  = (MAX_IN_WIDTH > 1) ? $clog2(MAX_IN_WIDTH) : 1;
  localparam int WEW = $clog2(MAX_IN_WIDTH + 1);
  localparam int RW  = (MAX_IN_HEIGHT > 1) ? $clog2(MAX_IN_HEIGHT) : 1;
  localparam int HEW = $clog2(MAX_IN_HEIGHT + 1);
  localparam int DW  = $clog2(nus3g_pkg::MAX_IN_DEPTH);
  localparam int DEW = $clog2(nus3g_pkg::MAX_IN_DEPTH + 1);

  logic [nus3g_pkg::SCALE_BITS-1:0]      scale;
  logic [nus3g_pkg::WIDTH_REG_BITS-1:0]  in_width;
  logic [nus3g_pkg::HEIGHT_REG_BITS-1:0] in_height;
  logic [nus3g_pkg::DEPTH_REG_BITS-1:0]  in_depth;
  logic [nus3g_pkg::PLANE_BITS-1:0]      plane_total;

  logic [SW-1:0]  sub_col;
  logic [CW-1:0]  in_col;
  logic [SW-1:0]  sub_row;
  logic [RW-1:0]  in_row;
  logic [SW-1:0]  sub_slab;
  logic [DW-1:0]  in_slab;
  logic [AW-1:0]  row_base;
  logic [nus3g_pkg::PLANE_BITS-1:0] plane_index;

  logic [SEW-1:0] s_eff;
  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic [DEW-1:0] d_eff;
  logic [SW-1:0]  s_m1;
  logic [CW-1:0]  w_m1;
  logic [RW-1:0]  h_m1;
  logic [DW-1:0]  d_m1;
  logic [nus3g_pkg::PLANE_BITS-1:0] planes_m1;

  logic sc_wrap, ic_wrap, sr_wrap, ir_wrap, ss_wrap, is_wrap;
  logic col_end, row_end, slab_end;
  logic known_index;

  // Out-of-range register values act as the nearest legal value.
  always_comb begin
    if (scale < nus3g_pkg::SCALE_BITS'(2)) begin
      s_eff = SEW'(2);
    end else if (int'(scale) > MAX_SCALE) begin
      s_eff = SEW'(MAX_SCALE);
    end else begin
      s_eff = SEW'(scale);
    end
    if (in_width == '0) begin
      w_eff = WEW'(1);
    end else if (int'(in_width) > MAX_IN_WIDTH) begin
      w_eff = WEW'(MAX_IN_WIDTH);
    end else begin
      w_eff = WEW'(in_width);
    end
    if (in_height == '0) begin
      h_eff = HEW'(1);
    end else if (int'(in_height) > MAX_IN_HEIGHT) begin
      h_eff = HEW'(MAX_IN_HEIGHT);
    end else begin
      h_eff = HEW'(in_height);
    end
    if (in_depth == '0) begin
      d_eff = DEW'(1);
    end else if (int'(in_depth) > nus3g_pkg::MAX_IN_DEPTH) begin
      d_eff = DEW'(nus3g_pkg::MAX_IN_DEPTH);
    end else begin
      d_eff = DEW'(in_depth);
    end
    planes_m1 = (plane_total == '0) ? '0 : plane_total - 1'b1;
    s_m1 = SW'(s_eff - SEW'(1));
    w_m1 = CW'(w_eff - WEW'(1));
    h_m1 = RW'(h_eff - HEW'(1));
    d_m1 = DW'(d_eff - DEW'(1));
  end

  assign sc_wrap  = (sub_col == s_m1);
  assign ic_wrap  = (in_col == w_m1);
  assign sr_wrap  = (sub_row == s_m1);
  assign ir_wrap  = (in_row == h_m1);
  assign ss_wrap  = (sub_slab == s_m1);
  assign is_wrap  = (in_slab == d_m1);
  assign col_end  = sc_wrap && ic_wrap;
  assign row_end  = col_end && sr_wrap && ir_wrap;
  assign slab_end = row_end && ss_wrap && is_wrap;

  assign addr      = row_base + AW'(in_col);
  assign pos.first = (sub_col == '0) && (sub_row == '0) && (sub_slab == '0);
  assign pos.last  = sc_wrap && sr_wrap && ss_wrap;
  assign pos.pend  = ic_wrap && ir_wrap && is_wrap;

  always_comb begin
    unique case (nus3g_pkg::cfg_index_t'(cfg_index))
      nus3g_pkg::CFG_SCALE,
      nus3g_pkg::CFG_IN_WIDTH,
      nus3g_pkg::CFG_IN_HEIGHT,
      nus3g_pkg::CFG_IN_DEPTH,
      nus3g_pkg::CFG_PLANE_TOTAL: known_index = 1'b1;
      default:                    known_index = 1'b0;
    endcase
  end

  // A write to an unknown index is ignored and leaves the counters running.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale       <= nus3g_pkg::SCALE_BITS'(2);
      in_width    <= nus3g_pkg::WIDTH_REG_BITS'(1);
      in_height   <= nus3g_pkg::HEIGHT_REG_BITS'(1);
      in_depth    <= nus3g_pkg::DEPTH_REG_BITS'(1);
      plane_total <= nus3g_pkg::PLANE_BITS'(1);
      sub_col     <= '0;
      in_col      <= '0;
      sub_row     <= '0;
      in_row      <= '0;
      sub_slab    <= '0;
      in_slab     <= '0;
      row_base    <= '0;
      plane_index <= '0;
    end else if (cfg_we && known_index) begin
      unique case (nus3g_pkg::cfg_index_t'(cfg_index))
        nus3g_pkg::CFG_SCALE:       scale <= cfg_data[nus3g_pkg::SCALE_BITS-1:0];
        nus3g_pkg::CFG_IN_WIDTH:    in_width <= cfg_data[nus3g_pkg::WIDTH_REG_BITS-1:0];
        nus3g_pkg::CFG_IN_HEIGHT:   in_height <= cfg_data[nus3g_pkg::HEIGHT_REG_BITS-1:0];
        nus3g_pkg::CFG_IN_DEPTH:    in_depth <= cfg_data[nus3g_pkg::DEPTH_REG_BITS-1:0];
        nus3g_pkg::CFG_PLANE_TOTAL: plane_total <= cfg_data[nus3g_pkg::PLANE_BITS-1:0];
        default: begin
        end
      endcase
      // A write to a known register restarts the stream; the sums stay.
      sub_col     <= '0;
      in_col      <= '0;
      sub_row     <= '0;
      in_row      <= '0;
      sub_slab    <= '0;
      in_slab     <= '0;
      row_base    <= '0;
      plane_index <= '0;
    end else if (advance) begin
      if (!sc_wrap) begin
        sub_col <= sub_col + 1'b1;
      end else begin
        sub_col <= '0;
        in_col  <= ic_wrap ? '0 : in_col + 1'b1;
      end
      if (col_end) begin
        if (!sr_wrap) begin
          sub_row <= sub_row + 1'b1;
        end else begin
          sub_row  <= '0;
          in_row   <= ir_wrap ? '0 : in_row + 1'b1;
          row_base <= ir_wrap ? '0 : row_base + AW'(w_eff);
        end
      end
      if (row_end) begin
        if (!ss_wrap) begin
          sub_slab <= sub_slab + 1'b1;
        end else begin
          sub_slab <= '0;
          in_slab  <= is_wrap ? '0 : in_slab + 1'b1;
        end
      end
      if (slab_end) begin
        plane_index <= (plane_index >= planes_m1) ? '0 : plane_index + 1'b1;
      end
    end
  end

endmodule

### rtl/nus3g_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nus3g_accum
// Read-modify-write of the block sums with forwarding, and the result register.
// ----------------------------------------------------------------------------
`include "nearest_upsample_3d_gradient_sum_unit_macros.svh"

module nus3g_accum #(
  parameter int DEPTH       = 4096,
  parameter int SAMPLE_BITS = 32,
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [AW-1:0]                 addr,
  input  nus3g_pkg::pos_t               pos,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nus3g_pkg::sum_t               out_sum,
  output logic                          out_pend
);

  logic                 s1_valid;
  logic [AW-1:0]        s1_addr;
  nus3g_pkg::pos_t      s1_pos;
  nus3g_pkg::sum_t      s1_sample;
  logic                 s1_fwd;
  nus3g_pkg::sum_t      last_wdata;
  nus3g_pkg::sum_t      rdata;
  nus3g_pkg::sum_t      operand;
  nus3g_pkg::sum_t      sum;
  logic                 s1_retire;

  // A sample that closes a block can only leave when the result slot frees up.
  assign s1_retire = s1_valid && (!s1_pos.last || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_retire;

  // The entry read alongside the previous item's write comes from last_wdata.
  always_comb begin
    if (s1_pos.first) begin
      operand = '0;
    end else if (s1_fwd) begin
      operand = last_wdata;
    end else begin
      operand = rdata;
    end
    sum = operand + s1_sample;
  end

  nus3g_ram #(
    .WIDTH (nus3g_pkg::SUM_BITS),
    .DEPTH (DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (s1_retire),
    .waddr (s1_addr),
    .wdata (sum),
    .re    (accept),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_retire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr   <= addr;
      s1_pos    <= pos;
      s1_sample <= nus3g_pkg::sum_t'(sample);
      s1_fwd    <= s1_retire && (s1_addr == addr);
    end
    if (s1_retire) begin
      last_wdata <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_retire && s1_pos.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_retire && s1_pos.last) begin
      out_sum  <= sum;
      out_pend <= s1_pos.pend;
    end
  end

  `NUS3G_CHECK(a_stall_hold, s1_valid && !s1_retire |=> s1_valid && $stable(s1_addr), "stalled item moved")
  `NUS3G_CHECK(a_fwd_set, accept && s1_retire && (s1_addr == addr) |=> s1_fwd, "forward flag missing")
  `NUS3G_CHECK(a_result_out, s1_retire && s1_pos.last |=> out_valid, "closed block gave no result")
  `NUS3G_CHECK_RST(a_reset_idle, rst |=> !s1_valid && !out_valid, "pipeline not empty after reset")

endmodule

### rtl/nearest_upsample_3d_gradient_sum_unit.sv
`timescale 1ns / 1ps
// The unit takes one gradient sample per clock while its input is not held off, and
// presents a block sum in its output register once the sample that closes the block has
// left the s1 stage. The rate is set by a single read-modify-write of the accumulator RAM
// per sample; a read of the entry being written returns old data, so the previous write is
// forwarded. The input is held off only while a sample that closes a block waits for the
// previous sum to be taken. The accumulator needs no clearing pass after reset: the first
// sample of each block overwrites its entry. A write to any of the five registers restarts
// the stream at the first sample; a write to an unknown index is ignored.
// ----------------------------------------------------------------------------
// nearest_upsample_3d_gradient_sum_unit
// Sums each scale x scale x scale block of upsampled gradients per input voxel.
// ----------------------------------------------------------------------------
module nearest_upsample_3d_gradient_sum_unit #(
  parameter int MAX_IN_WIDTH  = 64,
  parameter int MAX_IN_HEIGHT = 64,
  parameter int MAX_SCALE     = 8,
  parameter int SAMPLE_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [nus3g_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [nus3g_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  nus3g_in_if.sink                             grad_in,
  nus3g_out_if.source                          grad_out
);

  localparam int ENTRIES = MAX_IN_WIDTH * MAX_IN_HEIGHT;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic            ready;
  logic            accept;
  logic [AW-1:0]   addr;
  nus3g_pkg::pos_t pos;

  assign accept        = grad_in.valid && ready;
  assign grad_in.ready = ready;

  nus3g_seq #(
    .MAX_IN_WIDTH  (MAX_IN_WIDTH),
    .MAX_IN_HEIGHT (MAX_IN_HEIGHT),
    .MAX_SCALE     (MAX_SCALE)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .addr      (addr),
    .pos       (pos)
  );

  nus3g_accum #(
    .DEPTH       (ENTRIES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_ready  (ready),
    .sample    (grad_in.grad_value),
    .addr      (addr),
    .pos       (pos),
    .out_valid (grad_out.valid),
    .out_ready (grad_out.ready),
    .out_sum   (grad_out.grad_sum),
    .out_pend  (grad_out.plane_end)
  );

endmodule
